>>> sv/mss_pkg.sv
// Shared types and constants for the motion safety supervisor.
package mss_pkg;

  localparam int AGE_WIDTH     = 16;
  localparam int TIMEOUT_WIDTH = 16;
  localparam int CMP_WIDTH     = (AGE_WIDTH > TIMEOUT_WIDTH) ? AGE_WIDTH : TIMEOUT_WIDTH;

  typedef enum logic [2:0] {
    MODE_BOOTING = 3'd0,
    MODE_READY   = 3'd1,
    MODE_MOVING  = 3'd2,
    MODE_FAULT   = 3'd3,
    MODE_ESTOP   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_REQUEST_READY = 3'd1,
    OP_ESTOP         = 3'd2,
    OP_CLEAR_FAULTS  = 3'd3,
    OP_COMMAND       = 3'd4
  } op_t;

  typedef struct packed {
    logic [AGE_WIDTH-1:0] command_age;
    logic                 config_fault;
    mode_t                mode;
  } sup_state_t;

  typedef struct packed {
    mode_t mode;
    logic  stop_motion;
    logic  disable_drivers;
    logic  motion_allowed;
    logic  clear_accepted;
    logic  config_fault_flag;
    logic  comm_timed_out;
  } sup_result_t;

endpackage

>>> sv/motion_safety_supervisor.sv
// Top level of the motion safety supervisor: request register, update stage, result register.
//
// Motion safety supervisor. Each request carries an operation (tick, request
// ready, emergency stop, clear faults, command received) with the current
// config-valid and axis-moving flags, and produces exactly one result with the
// new mode, the stop-motion and disable-drivers pulses, motion allowed, the
// outcome of a clear, the sticky config fault and the watchdog pulse. A
// request is taken into an input register; it is applied to the mode, fault
// and command-age registers, and its result written to an output register,
// once that output register is free or being read. One request per cycle
// is accepted while results are taken. The rate is set by the update of the
// supervisor state, which each request reads and writes. The command age
// counts ticks and saturates at all ones; a comm_timeout_ticks of zero
// switches the watchdog off. Write comm_timeout_ticks only while no request
// is in flight.
module motion_safety_supervisor (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic        config_valid,
  input  logic        any_axis_moving,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic        stop_motion,
  output logic        disable_drivers,
  output logic        motion_allowed,
  output logic        clear_accepted,
  output logic        config_fault_flag,
  output logic        comm_timed_out
);

  logic [mss_pkg::TIMEOUT_WIDTH-1:0] comm_timeout;

  // Input register holding one request.
  logic       req_valid;
  logic [2:0] req_op;
  logic       req_cfg_ok;
  logic       req_moving;

  mss_pkg::sup_state_t  state;
  mss_pkg::sup_state_t  state_next;
  mss_pkg::sup_result_t result_next;
  mss_pkg::sup_result_t result;

  logic advance;

  // Advance the held request when the result register is free or draining.
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      comm_timeout <= '0;
    end else if (cfg_we) begin
      comm_timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  // Payload needs no reset; capture on acceptance only.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op     <= operation;
      req_cfg_ok <= config_valid;
      req_moving <= any_axis_moving;
    end
  end

  mss_update u_update (
    .state              (state),
    .comm_timeout_ticks (comm_timeout),
    .operation          (req_op),
    .config_valid       (req_cfg_ok),
    .any_axis_moving    (req_moving),
    .state_next         (state_next),
    .result             (result_next)
  );

  // Supervisor state: commit only when a request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= mss_pkg::MODE_BOOTING;
      state.config_fault <= 1'b0;
      state.command_age  <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign mode              = result.mode;
  assign stop_motion       = result.stop_motion;
  assign disable_drivers   = result.disable_drivers;
  assign motion_allowed    = result.motion_allowed;
  assign clear_accepted    = result.clear_accepted;
  assign config_fault_flag = result.config_fault_flag;
  assign comm_timed_out    = result.comm_timed_out;

endmodule

>>> sv/mss_update.sv
// Next-state and result logic for one supervisor request.
module mss_update (
  input  mss_pkg::sup_state_t             state,
  input  logic [mss_pkg::TIMEOUT_WIDTH-1:0] comm_timeout_ticks,
  input  logic [2:0]                      operation,
  input  logic                            config_valid,
  input  logic                            any_axis_moving,
  output mss_pkg::sup_state_t             state_next,
  output mss_pkg::sup_result_t            result
);

  logic [mss_pkg::AGE_WIDTH-1:0] age_inc;
  logic                          timed_out;
  logic                          stop;
  logic                          disable_drv;
  logic                          accepted;
  mss_pkg::mode_t                m;
  logic                          cf;
  logic [mss_pkg::AGE_WIDTH-1:0] age;

  // Saturating increment of the command age.
  assign age_inc = (&state.command_age) ? state.command_age
                                        : state.command_age + 1'b1;

  always_comb begin
    m           = state.mode;
    cf          = state.config_fault;
    age         = state.command_age;
    stop        = 1'b0;
    disable_drv = 1'b0;
    accepted    = 1'b0;
    timed_out   = 1'b0;
    case (mss_pkg::op_t'(operation))
      mss_pkg::OP_TICK: begin
        age = age_inc;
        if (!config_valid) cf = 1'b1;
        if ((comm_timeout_ticks != '0) &&
            (m == mss_pkg::MODE_READY || m == mss_pkg::MODE_MOVING) &&
            (mss_pkg::CMP_WIDTH'(age_inc) > mss_pkg::CMP_WIDTH'(comm_timeout_ticks))) begin
          stop      = 1'b1;
          timed_out = 1'b1;
          m         = mss_pkg::MODE_READY;
          age       = '0;
        end
        if ((m == mss_pkg::MODE_READY || m == mss_pkg::MODE_MOVING) && cf) begin
          stop        = 1'b1;
          disable_drv = 1'b1;
          m           = mss_pkg::MODE_FAULT;
        end
        if (m == mss_pkg::MODE_READY && any_axis_moving) begin
          m = mss_pkg::MODE_MOVING;
        end else if (m == mss_pkg::MODE_MOVING && !any_axis_moving) begin
          m = mss_pkg::MODE_READY;
        end
      end
      mss_pkg::OP_REQUEST_READY: begin
        if (!config_valid) cf = 1'b1;
        if (cf) begin
          m           = mss_pkg::MODE_FAULT;
          disable_drv = 1'b1;
        end else begin
          m = mss_pkg::MODE_READY;
        end
      end
      mss_pkg::OP_ESTOP: begin
        stop        = 1'b1;
        disable_drv = 1'b1;
        m           = mss_pkg::MODE_ESTOP;
      end
      mss_pkg::OP_CLEAR_FAULTS: begin
        if (!config_valid) begin
          cf = 1'b1;
        end else if (m != mss_pkg::MODE_ESTOP) begin
          cf          = 1'b0;
          m           = mss_pkg::MODE_BOOTING;
          disable_drv = 1'b1;
          accepted    = 1'b1;
        end
      end
      mss_pkg::OP_COMMAND: begin
        age = '0;
      end
      default: begin
      end
    endcase
  end

  assign state_next.mode         = m;
  assign state_next.config_fault = cf;
  assign state_next.command_age  = age;

  assign result.mode              = m;
  assign result.stop_motion       = stop;
  assign result.disable_drivers   = disable_drv;
  assign result.motion_allowed    = (m == mss_pkg::MODE_READY || m == mss_pkg::MODE_MOVING) && !cf;
  assign result.clear_accepted    = accepted;
  assign result.config_fault_flag = cf;
  assign result.comm_timed_out    = timed_out;

endmodule
